[rtl/core/csbc_pkg.sv]
// ----------------------------------------------------------------------------
// csbc_pkg
// Shared types and byte codes for the C syntax balance checker.
// ----------------------------------------------------------------------------
package csbc_pkg;

	// Lexer modes
	typedef enum logic [2:0] {
		MODE_NORMAL     = 3'd0,
		MODE_SLASH      = 3'd1,
		MODE_COMMENT    = 3'd2,
		MODE_CSTAR      = 3'd3,
		MODE_STRING     = 3'd4,
		MODE_STRING_ESC = 3'd5,
		MODE_CHAR       = 3'd6,
		MODE_CHAR_ESC   = 3'd7
	} mode_t;

	// ASCII codes
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;

	// Width of a reported net count
	localparam int RPT_WIDTH = 16;

	// Per-item control for one net counter
	typedef struct packed {
		logic up;     // opening byte seen
		logic down;   // closing byte seen
		logic clear;  // end of text: reload zero after this item
		logic en;     // an item is processed this cycle
	} cnt_ctl_t;

endpackage

[rtl/core/csbc_counter.sv]
// ----------------------------------------------------------------------------
// csbc_counter
// Saturating signed net counter with clamped 16-bit report value.
// ----------------------------------------------------------------------------
module csbc_counter
	import csbc_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cnt_ctl_t                    ctl,
	output logic                        hit,      // limit reached on this item
	output logic                        clamped,  // report value was clamped
	output logic                        is_zero,
	output logic [RPT_WIDTH-1:0]        rpt
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] cnt_d;

	always_comb begin
		cnt_d = cnt_q;
		hit   = 1'b0;
		if (ctl.up) begin
			if (cnt_q == CNT_MAX) begin
				hit = 1'b1;
			end else begin
				cnt_d = cnt_q + CNT_ONE;
			end
		end else if (ctl.down) begin
			if (cnt_q == CNT_MIN) begin
				hit = 1'b1;
			end else begin
				cnt_d = cnt_q - CNT_ONE;
			end
		end
	end

	assign is_zero = (cnt_d == '0);

	generate
		if (COUNT_WIDTH > RPT_WIDTH) begin : g_wide
			logic over;
			logic under;
			assign over  = !cnt_d[COUNT_WIDTH-1] && (|cnt_d[COUNT_WIDTH-2:RPT_WIDTH-1]);
			assign under = cnt_d[COUNT_WIDTH-1] && !(&cnt_d[COUNT_WIDTH-2:RPT_WIDTH-1]);
			assign clamped = over || under;
			assign rpt = over  ? {1'b0, {(RPT_WIDTH-1){1'b1}}} :
			             under ? {1'b1, {(RPT_WIDTH-1){1'b0}}} :
			                     cnt_d[RPT_WIDTH-1:0];
		end else if (COUNT_WIDTH == RPT_WIDTH) begin : g_equal
			assign clamped = 1'b0;
			assign rpt     = cnt_d;
		end else begin : g_narrow
			assign clamped = 1'b0;
			assign rpt     = {{(RPT_WIDTH-COUNT_WIDTH){cnt_d[COUNT_WIDTH-1]}}, cnt_d};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.en) begin
			cnt_q <= ctl.clear ? '0 : cnt_d;
		end
	end

endmodule

[rtl/core/c_syntax_balance_checker_core.sv]
// ----------------------------------------------------------------------------
// c_syntax_balance_checker_core
// Streaming C comment stripper and bracket balance checker.
// ----------------------------------------------------------------------------
// Takes C source one byte per item on the s_ stream (byte in s_tdata, s_tlast
// on the final byte of a text) and returns one report item per text on the
// m_ stream, sent after the last byte. Block comments are skipped; string and
// char literals, with backslash escapes, are tracked so that brackets inside
// them are not counted. Net counts of (), [] and {} are COUNT_WIDTH bits wide,
// saturate at their signed limits and set count_saturated; wider counts are
// clamped to 16 bits on report, which also sets count_saturated. After the
// report all state returns to its reset values. Throughput is one byte per
// cycle unless a last byte stalls: each byte waits in the input register
// while the lexer mode and the three counters update from it, and the
// report of a last byte is registered in the output register the same cycle.
// The input side keeps accepting bytes while a report waits; only a second
// last byte stalls until the pending report is taken.
// ----------------------------------------------------------------------------
module c_syntax_balance_checker_core
	import csbc_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] open_string, [1] open_char_const, [17:2] paren_net,
	// [33:18] bracket_net, [49:34] brace_net, [50] count_saturated,
	// [51] all_balanced, [55:52] zero
	output logic [55:0] m_tdata
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Lexer state
	mode_t mode_q;
	mode_t mode_d;
	logic  sat_q;

	// Output register
	logic        out_valid_q;
	logic [55:0] out_data_q;

	logic process;   // the byte in the input register is consumed now
	logic code_evt;  // byte is handled as ordinary code

	// A last byte needs the output register free (or freeing this cycle).
	assign process  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Next mode; code bytes come from normal mode or a held slash not
	// followed by a star.
	always_comb begin
		code_evt = 1'b0;
		mode_d   = mode_q;
		case (mode_q)
			MODE_NORMAL, MODE_SLASH: begin
				if (mode_q == MODE_SLASH && byte_s1 == CH_STAR) begin
					mode_d = MODE_COMMENT;
				end else begin
					code_evt = 1'b1;
					if (byte_s1 == CH_SLASH) begin
						mode_d = MODE_SLASH;
					end else if (byte_s1 == CH_DQUOTE) begin
						mode_d = MODE_STRING;
					end else if (byte_s1 == CH_SQUOTE) begin
						mode_d = MODE_CHAR;
					end else begin
						mode_d = MODE_NORMAL;
					end
				end
			end
			MODE_COMMENT: begin
				mode_d = (byte_s1 == CH_STAR) ? MODE_CSTAR : MODE_COMMENT;
			end
			MODE_CSTAR: begin
				if (byte_s1 == CH_SLASH) begin
					mode_d = MODE_NORMAL;
				end else if (byte_s1 == CH_STAR) begin
					mode_d = MODE_CSTAR;
				end else begin
					mode_d = MODE_COMMENT;
				end
			end
			MODE_STRING: begin
				if (byte_s1 == CH_BACKSLASH) begin
					mode_d = MODE_STRING_ESC;
				end else if (byte_s1 == CH_DQUOTE) begin
					mode_d = MODE_NORMAL;
				end else begin
					mode_d = MODE_STRING;
				end
			end
			MODE_STRING_ESC: mode_d = MODE_STRING;
			MODE_CHAR: begin
				if (byte_s1 == CH_BACKSLASH) begin
					mode_d = MODE_CHAR_ESC;
				end else if (byte_s1 == CH_SQUOTE) begin
					mode_d = MODE_NORMAL;
				end else begin
					mode_d = MODE_CHAR;
				end
			end
			MODE_CHAR_ESC: mode_d = MODE_CHAR;
			default: mode_d = MODE_NORMAL;
		endcase
	end

	// Counter controls
	cnt_ctl_t ctl_paren, ctl_bracket, ctl_brace;

	always_comb begin
		ctl_paren.en      = process;
		ctl_paren.clear   = last_s1;
		ctl_paren.up      = code_evt && byte_s1 == CH_LPAREN;
		ctl_paren.down    = code_evt && byte_s1 == CH_RPAREN;
		ctl_bracket.en    = process;
		ctl_bracket.clear = last_s1;
		ctl_bracket.up    = code_evt && byte_s1 == CH_LBRACKET;
		ctl_bracket.down  = code_evt && byte_s1 == CH_RBRACKET;
		ctl_brace.en      = process;
		ctl_brace.clear   = last_s1;
		ctl_brace.up      = code_evt && byte_s1 == CH_LBRACE;
		ctl_brace.down    = code_evt && byte_s1 == CH_RBRACE;
	end

	logic                 hit_p, hit_k, hit_b;
	logic                 clp_p, clp_k, clp_b;
	logic                 zero_p, zero_k, zero_b;
	logic [RPT_WIDTH-1:0] rpt_p, rpt_k, rpt_b;

	csbc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_paren (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_paren),
		.hit(hit_p), .clamped(clp_p), .is_zero(zero_p), .rpt(rpt_p)
	);

	csbc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_bracket (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_bracket),
		.hit(hit_k), .clamped(clp_k), .is_zero(zero_k), .rpt(rpt_k)
	);

	csbc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_brace (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_brace),
		.hit(hit_b), .clamped(clp_b), .is_zero(zero_b), .rpt(rpt_b)
	);

	// Report fields
	logic sat_d;
	logic open_s;
	logic open_c;
	logic sat_rpt;
	logic balanced;

	assign sat_d    = sat_q || hit_p || hit_k || hit_b;
	assign open_s   = (mode_d == MODE_STRING) || (mode_d == MODE_STRING_ESC);
	assign open_c   = (mode_d == MODE_CHAR) || (mode_d == MODE_CHAR_ESC);
	assign sat_rpt  = sat_d || clp_p || clp_k || clp_b;
	assign balanced = !open_s && !open_c && zero_p && zero_k && zero_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			sat_q  <= 1'b0;
		end else if (process) begin
			mode_q <= last_s1 ? MODE_NORMAL : mode_d;
			sat_q  <= last_s1 ? 1'b0 : sat_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && last_s1) begin
			out_data_q <= {4'b0000, balanced, sat_rpt, rpt_b, rpt_k, rpt_p, open_c, open_s};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
